@@ rtl/core/rpc_pkg.sv @@
// Shared constants and token type for the reverse pair counter.
`default_nettype none

package rpc_pkg;

  localparam int unsigned MAX_ITEMS = 1024;
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned PAIR_W    = 19;
  localparam int unsigned IDX_W     = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int unsigned CNT_W     = $clog2(MAX_ITEMS + 1);

  localparam logic [PAIR_W-1:0] COUNT_MAX = {PAIR_W{1'b1}};

  localparam longint unsigned PAIRS_MAX =
    (longint'(MAX_ITEMS) * (longint'(MAX_ITEMS) - 1)) / 2;
  localparam logic [PAIR_W-1:0] PAIR_LIMIT =
    (PAIRS_MAX > longint'(COUNT_MAX)) ? COUNT_MAX : PAIR_W'(PAIRS_MAX);

  // element travelling down the cell row
  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic                     last;
    logic                     drop;
    logic [IDX_W-1:0]         pos;
    logic [IDX_W-1:0]         hits;
  } token_t;

endpackage

`default_nettype wire

@@ rtl/core/rpc_if.sv @@
// Valid/ready channel interfaces for input elements and pair count results.
`default_nettype none

interface rpc_in_if;
  logic                                    valid;
  logic                                    ready;
  logic signed [rpc_pkg::DATA_W-1:0]       value;
  logic                                    last;

  modport source (output valid, output value, output last, input ready);
  modport sink   (input valid, input value, input last, output ready);
endinterface

interface rpc_out_if;
  logic                                    valid;
  logic                                    ready;
  logic [rpc_pkg::PAIR_W-1:0]              pair_count;
  logic                                    overflowed;

  modport source (output valid, output pair_count, output overflowed, input ready);
  modport sink   (input valid, input pair_count, input overflowed, output ready);
endinterface

`default_nettype wire

@@ rtl/core/rpc_cell.sv @@
// One storage cell: holds one element, counts matches and passes the token on.
`default_nettype none

module rpc_cell (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        en_i,
  input  wire logic [rpc_pkg::IDX_W-1:0]   idx_i,
  input  wire logic                        vld_i,
  input  wire rpc_pkg::token_t             tok_i,
  output logic                             vld_o,
  output rpc_pkg::token_t                  tok_o
);

  logic signed [rpc_pkg::DATA_W-1:0] stored_q;
  logic                              vld_q;
  rpc_pkg::token_t                   tok_q, tok_d;
  logic                              live;
  logic                              here;
  logic                              hit;

  always_comb begin
    live  = vld_i && !tok_i.drop;
    here  = live && (tok_i.pos == idx_i);
    hit   = live && (idx_i < tok_i.pos) &&
            ($signed({stored_q[rpc_pkg::DATA_W-1], stored_q}) >
             $signed({tok_i.value, 1'b0}));
    tok_d      = tok_i;
    tok_d.hits = tok_i.hits + rpc_pkg::IDX_W'(hit);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      tok_q <= tok_d;
    end
    if (en_i && here) begin
      stored_q <= tok_i.value;
    end
  end

  assign vld_o = vld_q;
  assign tok_o = tok_q;

endmodule

`default_nettype wire

@@ rtl/core/rpc_tail.sv @@
// End of the cell row: saturating set total, drop flag and result register.
`default_nettype none

module rpc_tail (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         en_i,
  input  wire logic                         vld_i,
  input  wire rpc_pkg::token_t              tok_i,
  input  wire logic                         out_ready_i,
  output logic                              out_valid_o,
  output logic [rpc_pkg::PAIR_W-1:0]        pair_count_o,
  output logic                              overflowed_o
);

  logic [rpc_pkg::PAIR_W-1:0] total_q;
  logic                       drop_q;
  logic                       out_valid_q;
  logic [rpc_pkg::PAIR_W-1:0] pair_q;
  logic                       ovf_q;
  logic [rpc_pkg::PAIR_W:0]   sum;
  logic [rpc_pkg::PAIR_W-1:0] sat;
  logic                       drop_any;
  logic                       take;

  always_comb begin
    take     = en_i && vld_i;
    sum      = {1'b0, total_q} + (rpc_pkg::PAIR_W + 1)'(tok_i.hits);
    sat      = (sum > {1'b0, rpc_pkg::COUNT_MAX}) ? rpc_pkg::COUNT_MAX
                                                  : sum[rpc_pkg::PAIR_W-1:0];
    drop_any = drop_q || tok_i.drop;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q     <= '0;
      drop_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (take) begin
        if (tok_i.last) begin
          total_q <= '0;
          drop_q  <= 1'b0;
        end else begin
          total_q <= sat;
          drop_q  <= drop_any;
        end
      end
      if (take && tok_i.last) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && tok_i.last) begin
      pair_q <= sat;
      ovf_q  <= drop_any;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign pair_count_o = pair_q;
  assign overflowed_o = ovf_q;

endmodule

`default_nettype wire

@@ rtl/core/reverse_pair_counter.sv @@
// Top level of the reverse pair counter: input stage, cell row and result stage.
// Counts pairs i<j in a set where the earlier value exceeds twice the later one
// (doubling done exactly at 33 bits). While no result waits on the output, one
// element is taken per cycle; each element becomes a token that walks a row of
// MAX_ITEMS cells, one cell per cycle, comparing against the value held in every
// earlier cell and writing itself into the cell at its own position. The closing
// element's result passes the input register, the cells and the result register,
// so elements overlap in flight and latency is set by the length of the cell row.
// Elements beyond MAX_ITEMS in a set are dropped and reported through overflowed.
// The whole row holds while a result waits on the output.
`default_nettype none

module reverse_pair_counter (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  rpc_in_if.sink      in_i,
  rpc_out_if.source   out_o
);

  localparam int unsigned N = rpc_pkg::MAX_ITEMS;

  logic                        advance;
  logic                        accept;
  logic                        room;
  logic [rpc_pkg::CNT_W-1:0]   cnt_q;
  logic                        head_vld_q;
  rpc_pkg::token_t             head_tok_q;
  logic                        vld [0:N];
  rpc_pkg::token_t             tok [0:N];
  logic                        out_valid;

  always_comb begin
    advance = !out_valid || out_o.ready;
    accept  = in_i.valid && advance;
    room    = cnt_q < rpc_pkg::CNT_W'(N);
  end

  assign in_i.ready = advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_vld_q <= 1'b0;
      cnt_q      <= '0;
    end else if (advance) begin
      head_vld_q <= accept;
      if (accept) begin
        if (in_i.last) begin
          cnt_q <= '0;
        end else if (room) begin
          cnt_q <= cnt_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      head_tok_q.value <= in_i.value;
      head_tok_q.last  <= in_i.last;
      head_tok_q.drop  <= !room;
      head_tok_q.pos   <= cnt_q[rpc_pkg::IDX_W-1:0];
      head_tok_q.hits  <= '0;
    end
  end

  assign vld[0] = head_vld_q;
  assign tok[0] = head_tok_q;

  for (genvar k = 0; k < N; k++) begin : g_cell
    rpc_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (advance),
      .idx_i  (rpc_pkg::IDX_W'(k)),
      .vld_i  (vld[k]),
      .tok_i  (tok[k]),
      .vld_o  (vld[k+1]),
      .tok_o  (tok[k+1])
    );
  end

  rpc_tail u_tail (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (advance),
    .vld_i        (vld[N]),
    .tok_i        (tok[N]),
    .out_ready_i  (out_o.ready),
    .out_valid_o  (out_valid),
    .pair_count_o (out_o.pair_count),
    .overflowed_o (out_o.overflowed)
  );

  assign out_o.valid = out_valid;

endmodule

`default_nettype wire

@@ rtl/core/rpc_checker.sv @@
// Port-level assertions for the reverse pair counter, bound to the top level.
`default_nettype none

module rpc_checker (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  input  wire logic                        in_ready_i,
  input  wire logic                        out_valid_i,
  input  wire logic                        out_ready_i,
  input  wire logic [rpc_pkg::PAIR_W-1:0]  pair_count_i,
  input  wire logic                        overflowed_i
);

  // result held until its transfer
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped before transfer");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(pair_count_i) && $stable(overflowed_i))
    else $error("result changed while stalled");

  // input only stalls behind a waiting result
  a_in_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> out_valid_i && !out_ready_i)
    else $error("input stalled without a waiting result");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> pair_count_i <= rpc_pkg::PAIR_LIMIT)
    else $error("pair count beyond possible pairs");

  a_no_early_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> !out_valid_i)
    else $error("result straight out of reset");

endmodule

bind reverse_pair_counter rpc_checker u_rpc_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .pair_count_i (out_o.pair_count),
  .overflowed_i (out_o.overflowed)
);

`default_nettype wire

@@ tb/testbench.sv @@
// Self-checking testbench for reverse_pair_counter: directed and random traffic, checked per transfer.
`default_nettype none

module testbench;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned PHASE_LEN   = 200;

  typedef struct {
    logic signed [rpc_pkg::DATA_W-1:0] value;
    logic                              last;
  } elem_t;

  typedef struct {
    logic [rpc_pkg::PAIR_W-1:0] pair_count;
    logic                       overflowed;
  } tally_t;

  typedef enum int {
    PH_STEADY,
    PH_SRC_GAPS,
    PH_SINK_STALLS,
    PH_BOTH_IDLE
  } phase_e;

  logic clk_i;
  logic rst_ni;

  rpc_in_if  in_bus ();
  rpc_out_if out_bus ();

  reverse_pair_counter DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_bus),
    .out_o  (out_bus)
  );

  elem_t  pending_elems[$];
  tally_t expected_tallies[$];

  logic signed [rpc_pkg::DATA_W-1:0] set_vals [rpc_pkg::MAX_ITEMS];
  int unsigned set_len;
  int unsigned pairs_so_far;
  logic        set_overflow;

  int unsigned accepted_elems;
  int unsigned fail_count;
  int unsigned cycle_count;

  always #5 clk_i = ~clk_i;

  function automatic phase_e cur_phase();
    return phase_e'((accepted_elems / PHASE_LEN) % 4);
  endfunction

  function automatic int unsigned idle_pct(input bit sender);
    case (cur_phase())
      PH_STEADY:      return 0;
      PH_SRC_GAPS:    return sender ? 54 : 0;
      PH_SINK_STALLS: return sender ? 0 : 54;
      default:        return 6;
    endcase
  endfunction

  // running pair tally of the current set; closes the set on last
  task automatic absorb_element(input logic signed [rpc_pkg::DATA_W-1:0] v,
                                input logic closes);
    longint      doubled;
    int unsigned hit_cnt;
    tally_t      t;
    doubled = 2 * longint'(v);
    if (set_len < rpc_pkg::MAX_ITEMS) begin
      hit_cnt = 0;
      for (int unsigned k = 0; k < set_len; k++) begin
        if (longint'(set_vals[k]) > doubled) hit_cnt++;
      end
      pairs_so_far += hit_cnt;
      if (pairs_so_far > rpc_pkg::COUNT_MAX) pairs_so_far = rpc_pkg::COUNT_MAX;
      set_vals[set_len] = v;
      set_len++;
    end else begin
      set_overflow = 1'b1;
    end
    if (closes) begin
      t.pair_count = rpc_pkg::PAIR_W'(pairs_so_far);
      t.overflowed = set_overflow;
      expected_tallies.push_back(t);
      set_len      = 0;
      pairs_so_far = 0;
      set_overflow = 1'b0;
    end
  endtask

  task automatic push_elem(input logic signed [rpc_pkg::DATA_W-1:0] v, input logic l);
    elem_t e;
    e.value = v;
    e.last  = l;
    pending_elems.push_back(e);
  endtask

  task automatic push_pair(input logic signed [rpc_pkg::DATA_W-1:0] a,
                           input logic signed [rpc_pkg::DATA_W-1:0] b);
    push_elem(a, 1'b0);
    push_elem(b, 1'b1);
  endtask

  // driver
  always @(posedge clk_i or negedge rst_ni) begin : drive_in
    elem_t nxt;
    if (!rst_ni) begin
      in_bus.valid <= 1'b0;
      in_bus.value <= '0;
      in_bus.last  <= 1'b0;
    end else begin
      if (in_bus.valid && in_bus.ready) begin
        absorb_element(in_bus.value, in_bus.last);
        accepted_elems++;
      end
      if (!in_bus.valid || in_bus.ready) begin
        if (pending_elems.size() != 0 && $urandom_range(0, 99) >= idle_pct(1'b1)) begin
          nxt = pending_elems.pop_front();
          in_bus.valid <= 1'b1;
          in_bus.value <= nxt.value;
          in_bus.last  <= nxt.last;
        end else begin
          in_bus.valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i or negedge rst_ni) begin : watch_out
    tally_t want;
    if (!rst_ni) begin
      out_bus.ready <= 1'b0;
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        if (expected_tallies.size() == 0) begin
          $display("%0t: unexpected result: expected none, actual pair_count %0d overflowed %0b",
                   $time, out_bus.pair_count, out_bus.overflowed);
          fail_count++;
        end else begin
          want = expected_tallies.pop_front();
          if (out_bus.pair_count !== want.pair_count) begin
            $display("%0t: pair_count expected %0d actual %0d",
                     $time, want.pair_count, out_bus.pair_count);
            fail_count++;
          end
          if (out_bus.overflowed !== want.overflowed) begin
            $display("%0t: overflowed expected %0b actual %0b",
                     $time, want.overflowed, out_bus.overflowed);
            fail_count++;
          end
        end
      end
      out_bus.ready <= ($urandom_range(0, 99) >= idle_pct(1'b0));
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin : stimulus
    int unsigned queued;
    int unsigned len;
    int unsigned mode;
    logic signed [rpc_pkg::DATA_W-1:0] v;

    clk_i          = 1'b0;
    rst_ni         = 1'b0;
    in_bus.valid   = 1'b0;
    in_bus.value   = '0;
    in_bus.last    = 1'b0;
    out_bus.ready  = 1'b0;
    set_len        = 0;
    pairs_so_far   = 0;
    set_overflow   = 1'b0;
    accepted_elems = 0;
    fail_count     = 0;
    cycle_count    = 0;

    // directed: single element, doubling past 32 bits, strict comparison
    push_elem(32'sd5, 1'b1);
    push_elem(32'sh7FFF_FFFF, 1'b1);
    push_elem(32'sh8000_0000, 1'b1);
    push_pair(32'sh7FFF_FFFF, 32'sh8000_0000);
    push_pair(32'sh8000_0000, 32'sh7FFF_FFFF);
    push_pair(32'sh8000_0000, 32'sh8000_0000);
    push_pair(32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
    push_pair(32'sh7FFF_FFFF, 32'sh3FFF_FFFF);
    push_pair(32'sh7FFF_FFFF, 32'sh4000_0000);
    push_pair(32'sd1, 32'sd0);
    push_pair(32'sd0, 32'sd0);
    push_pair(32'sd2, 32'sd1);
    push_pair(32'sd3, 32'sd1);
    push_pair(-32'sd1, -32'sd1);
    push_pair(-32'sd3, -32'sd2);

    // full row at the largest count, then an overrun whose closing element is dropped
    for (int unsigned i = 0; i < rpc_pkg::MAX_ITEMS; i++) push_elem(-32'sd1, 1'b0);
    push_elem(32'sh8000_0000, 1'b0);
    push_elem(32'sh8000_0000, 1'b1);

    // random sets, mostly short
    queued = 0;
    while (queued < 60) begin
      case ($urandom_range(0, 19))
        0:       len = $urandom_range(17, 40);
        1, 2, 3: len = $urandom_range(5, 16);
        default: len = $urandom_range(1, 4);
      endcase
      mode = $urandom_range(0, 3);
      for (int unsigned i = 0; i < len; i++) begin
        case ((mode == 3) ? $urandom_range(0, 2) : mode)
          0:       v = $urandom;
          1:       v = $signed($urandom_range(0, 16)) - 32'sd8;
          default: begin
            case ($urandom_range(0, 2))
              0:       v = 32'sh7FFF_FFFF - $signed($urandom_range(0, 3));
              1:       v = 32'sh8000_0000 + $signed($urandom_range(0, 3));
              default: v = $urandom_range(0, 1) ? 32'sh4000_0000 : 32'shC000_0000;
            endcase
            v = v + $signed($urandom_range(0, 2)) - 32'sd1;
          end
        endcase
        push_elem(v, i == len - 1);
      end
      queued += len;
    end

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (pending_elems.size() != 0 || in_bus.valid) @(posedge clk_i);
    while (expected_tallies.size() != 0) @(posedge clk_i);
    repeat (rpc_pkg::MAX_ITEMS + 16) @(posedge clk_i);

    if (fail_count == 0 && expected_tallies.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

`default_nettype wire
